[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every rising clock edge outside reset.
`define S2B_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("s2b: property check failed");
// The condition must never be true at a rising clock edge outside reset.
`define S2B_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("s2b: forbidden condition seen");
`else
`define S2B_ASSERT(label, clk, rst_n, prop)
`define S2B_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

[rtl/s2b_pkg.sv]
`default_nettype none

package s2b_pkg;

	// Fixed field widths.
	localparam int COORD_W    = 16;
	localparam int ADDR_W     = 32;
	localparam int BLOCK_W    = 5;
	localparam int PAD_W      = 8;
	localparam int OFFSET_W   = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Stream payload widths.
	localparam int IN_DATA_W  = 2 * OFFSET_W + 2 * COORD_W + 2 * ADDR_W;
	localparam int OUT_DATA_W = 2 * ADDR_W;
	localparam int OUT_USER_W = 2;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TO_SPACE_MODE = 3'd0,
		REG_BLOCK_ROWS    = 3'd1,
		REG_BLOCK_COLS    = 3'd2,
		REG_PAD_TOP       = 3'd3,
		REG_PAD_LEFT      = 3'd4,
		REG_SPACE_ROWS    = 3'd5,
		REG_SPACE_COLS    = 3'd6,
		REG_CHANNELS      = 3'd7
	} cfg_reg_t;

	// Configuration register bank contents.
	typedef struct packed {
		logic               to_space_mode;
		logic [BLOCK_W-1:0] block_rows;
		logic [BLOCK_W-1:0] block_cols;
		logic [PAD_W-1:0]   pad_top;
		logic [PAD_W-1:0]   pad_left;
		logic [COORD_W-1:0] space_rows;
		logic [COORD_W-1:0] space_cols;
		logic [COORD_W-1:0] channels;
	} cfg_t;

	// One classified transfer waiting for its address computation.
	typedef struct packed {
		logic [COORD_W-1:0] pos_row;
		logic [COORD_W-1:0] pos_col;
		logic [COORD_W-1:0] chan;
		logic               oor;
		logic               last;
		logic               to_space;
		logic [ADDR_W-1:0]  origin;
		logic [ADDR_W-1:0]  batch;
	} xfer_t;

	// A channel count of zero behaves as one channel.
	function automatic logic [COORD_W-1:0] eff_channels(input logic [COORD_W-1:0] ch);
		logic [COORD_W-1:0] r;
		r = (ch == '0) ? COORD_W'(1) : ch;
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/space_to_batch_address_walker_top.sv]
`default_nettype none
`include "assert_macros.svh"

// Address walker for a two-dimensional space-to-batch or batch-to-space tile.
// An input request whose start flag is set while the walker is idle loads the
// block offsets, tile size and base addresses if the tile has nonzero rows and
// columns, and gives no result; each later input request gives one element
// transfer (space address, batch address, padding flag, direction, last flag),
// walking channels fastest, then columns, then rows. A start flag seen during a
// walk is ignored. Requests are taken one per cycle whenever the front queue
// (FIFO_DEPTH entries) has room, and results leave one per cycle while the
// output is not stalled; an accepted request's element is written into the
// queue, then loaded into the first multiplier stage (row times space columns),
// then into the output register through the second (times channels), and a
// stalled output holds every stage. The space address of a padding element is
// zero. Configuration writes take effect at once and are expected only while no
// request is still in flight.
module space_to_batch_address_walker_top #(
	parameter int FIFO_DEPTH = 4
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// Configuration write port.
	input  wire                                 cfg_wen,
	input  wire  [s2b_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [s2b_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	// Input stream.
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	// offset_row[3:0], offset_col[7:4], out_rows[23:8], out_cols[39:24],
	// space_base[71:40], batch_base[103:72]
	input  wire  [s2b_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// start_req[0]
	input  wire  [0:0]                          s_axis_tuser,
	// Output stream.
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// space_addr[31:0], batch_addr[63:32]
	output logic [s2b_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// out_of_range[0], write_to_space[1]
	output logic [s2b_pkg::OUT_USER_W-1:0]      m_axis_tuser,
	output logic                                m_axis_tlast
);
	import s2b_pkg::*;

	cfg_t  cfg_q;
	logic  queue_full;
	logic  push;
	xfer_t push_entry;
	logic  front_busy;
	logic  pop;
	xfer_t head;
	logic  head_valid;

	logic [ADDR_W-1:0] space_addr, batch_addr;
	logic              out_of_range, write_to_space;

	// Configuration register bank.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.to_space_mode <= 1'b0;
			cfg_q.block_rows    <= BLOCK_W'(1);
			cfg_q.block_cols    <= BLOCK_W'(1);
			cfg_q.pad_top       <= '0;
			cfg_q.pad_left      <= '0;
			cfg_q.space_rows    <= COORD_W'(1);
			cfg_q.space_cols    <= COORD_W'(1);
			cfg_q.channels      <= COORD_W'(1);
		end else if (cfg_wen) begin
			case (cfg_reg_t'(cfg_index))
				REG_TO_SPACE_MODE: cfg_q.to_space_mode <= cfg_wdata[0];
				REG_BLOCK_ROWS:    cfg_q.block_rows    <= cfg_wdata[BLOCK_W-1:0];
				REG_BLOCK_COLS:    cfg_q.block_cols    <= cfg_wdata[BLOCK_W-1:0];
				REG_PAD_TOP:       cfg_q.pad_top       <= cfg_wdata[PAD_W-1:0];
				REG_PAD_LEFT:      cfg_q.pad_left      <= cfg_wdata[PAD_W-1:0];
				REG_SPACE_ROWS:    cfg_q.space_rows    <= cfg_wdata[COORD_W-1:0];
				REG_SPACE_COLS:    cfg_q.space_cols    <= cfg_wdata[COORD_W-1:0];
				REG_CHANNELS:      cfg_q.channels      <= cfg_wdata[COORD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front: takes requests, tracks the walk and classifies each element.
	s2b_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.start_req  (s_axis_tuser[0]),
		.offset_row (s_axis_tdata[3:0]),
		.offset_col (s_axis_tdata[7:4]),
		.out_rows   (s_axis_tdata[23:8]),
		.out_cols   (s_axis_tdata[39:24]),
		.space_base (s_axis_tdata[71:40]),
		.batch_base (s_axis_tdata[103:72]),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry),
		.busy       (front_busy)
	);

	// Queue between the walk and the address pipeline.
	s2b_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	// Back: address arithmetic and output register.
	s2b_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.head_valid     (head_valid),
		.head           (head),
		.pop            (pop),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.space_addr     (space_addr),
		.batch_addr     (batch_addr),
		.out_of_range   (out_of_range),
		.write_to_space (write_to_space),
		.last           (m_axis_tlast)
	);

	assign m_axis_tdata = {batch_addr, space_addr};
	assign m_axis_tuser = {write_to_space, out_of_range};

	// A padding element never carries a space address.
	`S2B_ASSERT(a_pad_addr_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[31:0] == '0)
	// The walk ends only on the element marked last.
	`S2B_ASSERT(a_walk_ends_on_last, clk, arst_n, $fell(front_busy) |-> $past(push && push_entry.last))
	// The front never hands an element to a full queue.
	`S2B_ASSERT_NEVER(a_no_push_when_full, clk, arst_n, push && queue_full)

endmodule

`default_nettype wire

[rtl/s2b_front.sv]
`default_nettype none

module s2b_front (
	input  wire                             clk,
	input  wire                             arst_n,
	input  s2b_pkg::cfg_t                   cfg,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire                             start_req,
	input  wire  [s2b_pkg::OFFSET_W-1:0]    offset_row,
	input  wire  [s2b_pkg::OFFSET_W-1:0]    offset_col,
	input  wire  [s2b_pkg::COORD_W-1:0]     out_rows,
	input  wire  [s2b_pkg::COORD_W-1:0]     out_cols,
	input  wire  [s2b_pkg::ADDR_W-1:0]      space_base,
	input  wire  [s2b_pkg::ADDR_W-1:0]      batch_base,
	input  wire                             queue_full,
	output logic                            push,
	output s2b_pkg::xfer_t                  push_entry,
	output logic                            busy
);
	import s2b_pkg::*;

	localparam int POS_W = COORD_W + BLOCK_W + 1;

	typedef struct packed {
		logic [COORD_W-1:0] pos;
		logic               oor;
	} pos_t;

	// Space position idx * block + off - pad, flagged when outside [0, size).
	function automatic pos_t dim_position(
		input logic [COORD_W-1:0]  idx,
		input logic [BLOCK_W-1:0]  blk,
		input logic [OFFSET_W-1:0] off,
		input logic [PAD_W-1:0]    pad,
		input logic [COORD_W-1:0]  size
	);
		logic [POS_W-1:0] sum;
		logic [POS_W-1:0] diff;
		pos_t             r;
		sum   = POS_W'(idx) * POS_W'(blk) + POS_W'(off);
		diff  = sum - POS_W'(pad);
		r.oor = (sum < POS_W'(pad)) || (diff >= POS_W'(size));
		r.pos = diff[COORD_W-1:0];
		return r;
	endfunction

	logic                busy_q;
	logic [COORD_W-1:0]  row_q, col_q, chan_q;
	logic [OFFSET_W-1:0] off_row_q, off_col_q;
	logic [COORD_W-1:0]  rows_q, cols_q;
	logic [ADDR_W-1:0]   origin_q, cursor_q;

	logic               accept;
	logic [COORD_W-1:0] nch;
	pos_t               prow, pcol;
	logic               lc, lcol, lrow;

	// Items are taken whenever the queue has room.
	assign in_ready = !queue_full;
	assign accept   = in_valid && !queue_full;
	assign push     = accept && busy_q;
	assign busy     = busy_q;

	// Classify the current element of the walk.
	always_comb begin
		nch  = eff_channels(cfg.channels);
		prow = dim_position(row_q, cfg.block_rows, off_row_q, cfg.pad_top, cfg.space_rows);
		pcol = dim_position(col_q, cfg.block_cols, off_col_q, cfg.pad_left, cfg.space_cols);
		lc   = ({1'b0, chan_q} + (COORD_W+1)'(1)) >= {1'b0, nch};
		lcol = ({1'b0, col_q} + (COORD_W+1)'(1)) >= {1'b0, cols_q};
		lrow = ({1'b0, row_q} + (COORD_W+1)'(1)) >= {1'b0, rows_q};
	end

	always_comb begin
		push_entry.pos_row  = prow.pos;
		push_entry.pos_col  = pcol.pos;
		push_entry.chan     = chan_q;
		push_entry.oor      = prow.oor || pcol.oor;
		push_entry.last     = lc && lcol && lrow;
		push_entry.to_space = cfg.to_space_mode;
		push_entry.origin   = origin_q;
		push_entry.batch    = cursor_q;
	end

	// Tile start and the row, column, channel walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			row_q     <= '0;
			col_q     <= '0;
			chan_q    <= '0;
			off_row_q <= '0;
			off_col_q <= '0;
			rows_q    <= '0;
			cols_q    <= '0;
			origin_q  <= '0;
			cursor_q  <= '0;
		end else if (accept) begin
			if (!busy_q) begin
				if (start_req && out_rows != '0 && out_cols != '0) begin
					off_row_q <= offset_row;
					off_col_q <= offset_col;
					rows_q    <= out_rows;
					cols_q    <= out_cols;
					origin_q  <= space_base;
					cursor_q  <= batch_base;
					row_q     <= '0;
					col_q     <= '0;
					chan_q    <= '0;
					busy_q    <= 1'b1;
				end
			end else begin
				cursor_q <= cursor_q + ADDR_W'(1);
				if (!lc) begin
					chan_q <= chan_q + COORD_W'(1);
				end else begin
					chan_q <= '0;
					if (!lcol) begin
						col_q <= col_q + COORD_W'(1);
					end else begin
						col_q <= '0;
						if (!lrow) begin
							row_q <= row_q + COORD_W'(1);
						end else begin
							row_q  <= '0;
							busy_q <= 1'b0;
						end
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

[rtl/s2b_fifo.sv]
`default_nettype none

module s2b_fifo #(
	parameter int DEPTH = 4
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  s2b_pkg::xfer_t  push_entry,
	output logic            full,
	input  wire             pop,
	output s2b_pkg::xfer_t  head,
	output logic            head_valid
);
	import s2b_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	xfer_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

[rtl/s2b_back.sv]
`default_nettype none

module s2b_back (
	input  wire                          clk,
	input  wire                          arst_n,
	input  s2b_pkg::cfg_t                cfg,
	input  wire                          head_valid,
	input  s2b_pkg::xfer_t               head,
	output logic                         pop,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [s2b_pkg::ADDR_W-1:0]   space_addr,
	output logic [s2b_pkg::ADDR_W-1:0]   batch_addr,
	output logic                         out_of_range,
	output logic                         write_to_space,
	output logic                         last
);
	import s2b_pkg::*;

	logic                      advance;
	logic [2*COORD_W-1:0]      row_prod;
	logic [ADDR_W-1:0]         lin_next;
	logic [ADDR_W+COORD_W-1:0] chan_prod;
	logic [ADDR_W-1:0]         addr_next;

	logic              valid_s1;
	logic [ADDR_W-1:0] lin_s1;
	xfer_t             xfer_s1;

	logic              out_valid_q;
	logic [ADDR_W-1:0] space_addr_q, batch_addr_q;
	logic              oor_q, to_space_q, last_q;

	// The whole pipeline moves when the output register is free or drained.
	assign advance = !out_valid_q || out_ready;
	assign pop     = advance && head_valid;

	// Stage one: linear space position row * space_cols + col.
	always_comb begin
		row_prod = head.pos_row * cfg.space_cols;
		lin_next = ADDR_W'(row_prod) + ADDR_W'(head.pos_col);
	end

	// Stage two: scale by channels and add origin and channel index.
	always_comb begin
		chan_prod = lin_s1 * eff_channels(cfg.channels);
		addr_next = chan_prod[ADDR_W-1:0] + xfer_s1.origin + ADDR_W'(xfer_s1.chan);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= head_valid;
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lin_s1       <= lin_next;
			xfer_s1      <= head;
			space_addr_q <= xfer_s1.oor ? '0 : addr_next;
			batch_addr_q <= xfer_s1.batch;
			oor_q        <= xfer_s1.oor;
			to_space_q   <= xfer_s1.to_space;
			last_q       <= xfer_s1.last;
		end
	end

	assign out_valid      = out_valid_q;
	assign space_addr     = space_addr_q;
	assign batch_addr     = batch_addr_q;
	assign out_of_range   = oor_q;
	assign write_to_space = to_space_q;
	assign last           = last_q;

endmodule

`default_nettype wire

[tb/space_to_batch_address_walker_top_test.sv]
`timescale 1ns / 100ps

module space_to_batch_address_walker_top_test;

	localparam int CYCLE_LIMIT    = 300000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int TARGET_ITEMS   = 400;

	// One input request as it travels in tdata, lowest field last.
	typedef struct packed {
		logic [s2b_pkg::ADDR_W-1:0]   batch_base;
		logic [s2b_pkg::ADDR_W-1:0]   space_base;
		logic [s2b_pkg::COORD_W-1:0]  out_cols;
		logic [s2b_pkg::COORD_W-1:0]  out_rows;
		logic [s2b_pkg::OFFSET_W-1:0] offset_col;
		logic [s2b_pkg::OFFSET_W-1:0] offset_row;
	} tile_req_t;

	// One element transfer as the walker reports it.
	typedef struct packed {
		logic [s2b_pkg::ADDR_W-1:0] space_addr;
		logic [s2b_pkg::ADDR_W-1:0] batch_addr;
		logic                       oor;
		logic                       to_space;
		logic                       last;
	} xfer_result_t;

	typedef enum logic {STEP_REQUEST, STEP_REGISTER} step_kind_t;

	// One line of the opening script: a request or a register write.
	typedef struct {
		step_kind_t                   kind;
		bit                           start;
		tile_req_t                    req;
		s2b_pkg::cfg_reg_t            reg_idx;
		logic [s2b_pkg::CFG_DATA_W-1:0] reg_val;
		bit                           pinned;
		xfer_result_t                 want;
	} tile_step_t;

	logic                                 clk = 1'b0;
	logic                                 arst_n;
	logic                                 cfg_wen;
	logic [s2b_pkg::CFG_IDX_W-1:0]        cfg_index;
	logic [s2b_pkg::CFG_DATA_W-1:0]       cfg_wdata;
	logic                                 s_axis_tvalid;
	logic                                 s_axis_tready;
	// offset_row, offset_col, out_rows, out_cols, space_base, batch_base
	logic [s2b_pkg::IN_DATA_W-1:0]        s_axis_tdata;
	// start_req
	logic [0:0]                           s_axis_tuser;
	logic                                 m_axis_tvalid;
	logic                                 m_axis_tready;
	// space_addr, batch_addr
	logic [s2b_pkg::OUT_DATA_W-1:0]       m_axis_tdata;
	// out_of_range, write_to_space
	logic [s2b_pkg::OUT_USER_W-1:0]       m_axis_tuser;
	logic                                 m_axis_tlast;

	// Predictor copy of the register bank and the walk state.
	s2b_pkg::cfg_t                        cfg_model;
	bit                                   walk_busy;
	logic [s2b_pkg::COORD_W-1:0]          walk_row, walk_col, walk_chan;
	logic [s2b_pkg::OFFSET_W-1:0]         tile_off_row, tile_off_col;
	logic [s2b_pkg::COORD_W-1:0]          tile_rows, tile_cols;
	logic [s2b_pkg::ADDR_W-1:0]           space_origin_q, batch_cursor_q;

	xfer_result_t                         expected_xfers[$];
	tile_step_t                           tile_script[$];
	bit                                   pin_valid;
	xfer_result_t                         pin_want;
	bit                                   burst;
	int                                   mismatch_count = 0;
	int unsigned                          cycle_count = 0;

	space_to_batch_address_walker_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Hard stop in case the walker hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Advances the walk by one accepted request and returns 1 when it yields a transfer.
	function automatic bit walk_step(input bit start, input tile_req_t r,
		output xfer_result_t res);
		longint pr, pc, nch;
		bit     oor, lc, lcol, lrow;
		res = '0;
		if (!walk_busy) begin
			if (start && r.out_rows != 0 && r.out_cols != 0) begin
				tile_off_row   = r.offset_row;
				tile_off_col   = r.offset_col;
				tile_rows      = r.out_rows;
				tile_cols      = r.out_cols;
				space_origin_q = r.space_base;
				batch_cursor_q = r.batch_base;
				walk_row       = '0;
				walk_col       = '0;
				walk_chan      = '0;
				walk_busy      = 1'b1;
			end
			return 1'b0;
		end
		nch = (cfg_model.channels == 0) ? 64'd1 : longint'(cfg_model.channels);
		pr = longint'(walk_row) * longint'(cfg_model.block_rows) + longint'(tile_off_row)
			- longint'(cfg_model.pad_top);
		pc = longint'(walk_col) * longint'(cfg_model.block_cols) + longint'(tile_off_col)
			- longint'(cfg_model.pad_left);
		oor = (pr < 0) || (pr >= longint'(cfg_model.space_rows)) ||
			(pc < 0) || (pc >= longint'(cfg_model.space_cols));
		if (!oor)
			res.space_addr = 32'(longint'(space_origin_q) +
				(pr * longint'(cfg_model.space_cols) + pc) * nch + longint'(walk_chan));
		res.batch_addr = batch_cursor_q;
		res.oor        = oor;
		res.to_space   = cfg_model.to_space_mode;
		// An index at or past its bound counts as the end of that dimension.
		lc   = longint'(walk_chan) + 1 >= nch;
		lcol = longint'(walk_col) + 1 >= longint'(tile_cols);
		lrow = longint'(walk_row) + 1 >= longint'(tile_rows);
		res.last = lc && lcol && lrow;
		batch_cursor_q = batch_cursor_q + 1'b1;
		if (!lc) begin
			walk_chan = walk_chan + 1'b1;
		end else begin
			walk_chan = '0;
			if (!lcol) begin
				walk_col = walk_col + 1'b1;
			end else begin
				walk_col = '0;
				if (!lrow) begin
					walk_row = walk_row + 1'b1;
				end else begin
					walk_row  = '0;
					walk_busy = 1'b0;
				end
			end
		end
		return 1'b1;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want, got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	// Predicts on every accepted request and checks every accepted transfer.
	always @(posedge clk) begin : scoreboard
		xfer_result_t want, got;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (walk_step(s_axis_tuser[0], tile_req_t'(s_axis_tdata), want)) begin
					if (pin_valid)
						want = pin_want;
					expected_xfers.push_back(want);
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.space_addr = m_axis_tdata[31:0];
				got.batch_addr = m_axis_tdata[63:32];
				got.oor        = m_axis_tuser[0];
				got.to_space   = m_axis_tuser[1];
				got.last       = m_axis_tlast;
				if (expected_xfers.size() == 0) begin
					$display("%0t ns: unexpected transfer, expected none, actual %h",
						$time, got);
					mismatch_count++;
				end else begin
					want = expected_xfers.pop_front();
					check_field("space_addr", want.space_addr, got.space_addr);
					check_field("batch_addr", want.batch_addr, got.batch_addr);
					check_field("out_of_range", 32'(want.oor), 32'(got.oor));
					check_field("write_to_space", 32'(want.to_space), 32'(got.to_space));
					check_field("last", 32'(want.last), 32'(got.last));
				end
			end
		end
	end

	// Result side: a fresh random stall before each transfer.
	initial begin : result_sink
		int stall;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = burst ? 0 : $urandom_range(0, 9);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	function automatic tile_req_t make_request(input logic [3:0] orow, ocol,
		input logic [15:0] rows, cols, input logic [31:0] sbase, bbase);
		tile_req_t r;
		r.offset_row = orow;
		r.offset_col = ocol;
		r.out_rows   = rows;
		r.out_cols   = cols;
		r.space_base = sbase;
		r.batch_base = bbase;
		return r;
	endfunction

	function automatic tile_req_t random_request();
		return make_request(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			$urandom, $urandom);
	endfunction

	function automatic tile_step_t req_step(input bit start, input tile_req_t r);
		tile_step_t s;
		s.kind    = STEP_REQUEST;
		s.start   = start;
		s.req     = r;
		s.reg_idx = s2b_pkg::REG_TO_SPACE_MODE;
		s.reg_val = '0;
		s.pinned  = 1'b0;
		s.want    = '0;
		return s;
	endfunction

	// A tick whose request content is noise; start may be set and must be ignored.
	function automatic tile_step_t loose_tick();
		return req_step(1'($urandom_range(0, 1)), random_request());
	endfunction

	function automatic tile_step_t checked_tick(input logic [31:0] sa, ba,
		input bit oor, to_space, last);
		tile_step_t s;
		s = loose_tick();
		s.pinned = 1'b1;
		s.want   = '{space_addr: sa, batch_addr: ba, oor: oor, to_space: to_space, last: last};
		return s;
	endfunction

	function automatic tile_step_t reg_step(input s2b_pkg::cfg_reg_t idx,
		input logic [15:0] val);
		tile_step_t s;
		s = req_step(1'b0, '0);
		s.kind    = STEP_REGISTER;
		s.reg_idx = idx;
		s.reg_val = val;
		return s;
	endfunction

	// Offers one request with a random lead-in gap and waits until it is taken.
	task automatic send_request(input bit start, input tile_req_t r, input bit pinned,
		input xfer_result_t want);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= r;
		s_axis_tuser  <= start;
		pin_valid     <= pinned;
		pin_want      <= want;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Holds the input side until every transfer has arrived and the pipeline is quiet.
	task automatic drain_pipeline();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_xfers.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_reg(input s2b_pkg::cfg_reg_t idx, input logic [15:0] val);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			s2b_pkg::REG_TO_SPACE_MODE: cfg_model.to_space_mode = val[0];
			s2b_pkg::REG_BLOCK_ROWS:    cfg_model.block_rows    = val[4:0];
			s2b_pkg::REG_BLOCK_COLS:    cfg_model.block_cols    = val[4:0];
			s2b_pkg::REG_PAD_TOP:       cfg_model.pad_top       = val[7:0];
			s2b_pkg::REG_PAD_LEFT:      cfg_model.pad_left      = val[7:0];
			s2b_pkg::REG_SPACE_ROWS:    cfg_model.space_rows    = val;
			s2b_pkg::REG_SPACE_COLS:    cfg_model.space_cols    = val;
			s2b_pkg::REG_CHANNELS:      cfg_model.channels      = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : stimulus
		bit              settled;
		int              items_sent;
		int              tiles, ticks, nch;
		tile_req_t       r;
		s2b_pkg::cfg_t   c;

		arst_n        = 1'b0;
		cfg_wen       <= 1'b0;
		cfg_index     <= s2b_pkg::REG_TO_SPACE_MODE;
		cfg_wdata     <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		pin_valid     <= 1'b0;
		pin_want      <= '0;
		burst         = 1'b0;

		// Register and walk state as they come out of reset.
		cfg_model.to_space_mode = 1'b0;
		cfg_model.block_rows    = 5'd1;
		cfg_model.block_cols    = 5'd1;
		cfg_model.pad_top       = '0;
		cfg_model.pad_left      = '0;
		cfg_model.space_rows    = 16'd1;
		cfg_model.space_cols    = 16'd1;
		cfg_model.channels      = 16'd1;
		walk_busy      = 1'b0;
		walk_row       = '0;
		walk_col       = '0;
		walk_chan      = '0;
		tile_off_row   = '0;
		tile_off_col   = '0;
		tile_rows      = '0;
		tile_cols      = '0;
		space_origin_q = '0;
		batch_cursor_q = '0;

		// Idle requests without start and empty tiles produce nothing.
		tile_script.push_back(req_step(1'b0, make_request(0, 0, 3, 3, 0, 0)));
		tile_script.push_back(req_step(1'b1, make_request(15, 15, 16'hFFFF, 0, '1, '1)));
		tile_script.push_back(req_step(1'b1, make_request(0, 0, 0, 16'hFFFF, 0, 0)));
		// A single element tile under the reset settings.
		tile_script.push_back(req_step(1'b1, make_request(0, 0, 1, 1, 32'h1000, 32'h2000)));
		tile_script.push_back(checked_tick(32'h1000, 32'h2000, 1'b0, 1'b0, 1'b1));
		// Zero row block under a large top pad: every element is padding,
		// and the batch address wraps past the top.
		tile_script.push_back(reg_step(s2b_pkg::REG_TO_SPACE_MODE, 16'd1));
		tile_script.push_back(reg_step(s2b_pkg::REG_BLOCK_ROWS, 16'd0));
		tile_script.push_back(reg_step(s2b_pkg::REG_BLOCK_COLS, 16'd31));
		tile_script.push_back(reg_step(s2b_pkg::REG_PAD_TOP, 16'd255));
		tile_script.push_back(reg_step(s2b_pkg::REG_PAD_LEFT, 16'd0));
		tile_script.push_back(reg_step(s2b_pkg::REG_SPACE_ROWS, 16'hFFFF));
		tile_script.push_back(reg_step(s2b_pkg::REG_SPACE_COLS, 16'hFFFF));
		tile_script.push_back(reg_step(s2b_pkg::REG_CHANNELS, 16'd0));
		tile_script.push_back(req_step(1'b1, make_request(15, 15, 1, 2, '1, '1)));
		tile_script.push_back(checked_tick(32'h0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0));
		tile_script.push_back(checked_tick(32'h0, 32'h0, 1'b1, 1'b1, 1'b1));
		// The same tile in range, with the space address wrapping.
		tile_script.push_back(reg_step(s2b_pkg::REG_PAD_TOP, 16'd0));
		tile_script.push_back(req_step(1'b1,
			make_request(15, 15, 1, 2, 32'hFFFF_FFF0, 32'h8000_0000)));
		tile_script.push_back(loose_tick());
		tile_script.push_back(loose_tick());
		// Ordinary blocking with padding and two channels; the last row sits
		// on the final space row.
		tile_script.push_back(reg_step(s2b_pkg::REG_TO_SPACE_MODE, 16'd0));
		tile_script.push_back(reg_step(s2b_pkg::REG_BLOCK_ROWS, 16'd4));
		tile_script.push_back(reg_step(s2b_pkg::REG_BLOCK_COLS, 16'd16));
		tile_script.push_back(reg_step(s2b_pkg::REG_PAD_TOP, 16'd3));
		tile_script.push_back(reg_step(s2b_pkg::REG_PAD_LEFT, 16'd1));
		tile_script.push_back(reg_step(s2b_pkg::REG_SPACE_ROWS, 16'd5));
		tile_script.push_back(reg_step(s2b_pkg::REG_SPACE_COLS, 16'd7));
		tile_script.push_back(reg_step(s2b_pkg::REG_CHANNELS, 16'd2));
		tile_script.push_back(req_step(1'b1, make_request(3, 2, 2, 1, 32'h100, 32'h200)));
		repeat (4) tile_script.push_back(loose_tick());
		// Channel count shrinks mid-tile: the channel index past the new
		// bound ends that position.
		tile_script.push_back(reg_step(s2b_pkg::REG_CHANNELS, 16'hFFFF));
		tile_script.push_back(req_step(1'b1, make_request(0, 0, 1, 2, 0, 0)));
		repeat (3) tile_script.push_back(loose_tick());
		tile_script.push_back(reg_step(s2b_pkg::REG_CHANNELS, 16'd1));
		repeat (2) tile_script.push_back(loose_tick());

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Opening script: register writes only once the pipeline is quiet.
		settled = 1'b1;
		foreach (tile_script[i]) begin
			if (tile_script[i].kind == STEP_REGISTER) begin
				if (!settled) begin
					drain_pipeline();
					settled = 1'b1;
				end
				program_reg(tile_script[i].reg_idx, tile_script[i].reg_val);
			end else begin
				send_request(tile_script[i].start, tile_script[i].req,
					tile_script[i].pinned, tile_script[i].want);
				settled = 1'b0;
			end
		end

		// Random phases: new settings, then a few complete tiles with noise between them.
		items_sent = 0;
		while (items_sent < TARGET_ITEMS) begin
			drain_pipeline();
			burst = ($urandom_range(0, 3) == 0);
			c.to_space_mode = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 9))
				0:       c.block_rows = 5'd0;
				1:       c.block_rows = 5'($urandom_range(17, 31));
				default: c.block_rows = 5'($urandom_range(1, 16));
			endcase
			case ($urandom_range(0, 9))
				0:       c.block_cols = 5'd0;
				1:       c.block_cols = 5'($urandom_range(17, 31));
				default: c.block_cols = 5'($urandom_range(1, 16));
			endcase
			c.pad_top  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, 12));
			c.pad_left = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, 12));
			case ($urandom_range(0, 11))
				0:       c.space_rows = 16'd0;
				1:       c.space_rows = 16'hFFFF;
				2:       c.space_rows = 16'($urandom_range(0, 65535));
				default: c.space_rows = 16'($urandom_range(1, 24));
			endcase
			case ($urandom_range(0, 11))
				0:       c.space_cols = 16'd0;
				1:       c.space_cols = 16'hFFFF;
				2:       c.space_cols = 16'($urandom_range(0, 65535));
				default: c.space_cols = 16'($urandom_range(1, 24));
			endcase
			c.channels = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
			program_reg(s2b_pkg::REG_TO_SPACE_MODE, 16'(c.to_space_mode));
			program_reg(s2b_pkg::REG_BLOCK_ROWS, 16'(c.block_rows));
			program_reg(s2b_pkg::REG_BLOCK_COLS, 16'(c.block_cols));
			program_reg(s2b_pkg::REG_PAD_TOP, 16'(c.pad_top));
			program_reg(s2b_pkg::REG_PAD_LEFT, 16'(c.pad_left));
			program_reg(s2b_pkg::REG_SPACE_ROWS, c.space_rows);
			program_reg(s2b_pkg::REG_SPACE_COLS, c.space_cols);
			program_reg(s2b_pkg::REG_CHANNELS, c.channels);

			nch = (c.channels == 0) ? 1 : int'(c.channels);
			tiles = $urandom_range(1, 4);
			repeat (tiles) begin
				// Noise the idle walker must ignore: no start, or an empty tile.
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 2)) begin
						r = random_request();
						if ($urandom_range(0, 1) == 0) begin
							send_request(1'b0, r, 1'b0, '0);
						end else begin
							if ($urandom_range(0, 1) == 0)
								r.out_rows = '0;
							else
								r.out_cols = '0;
							send_request(1'b1, r, 1'b0, '0);
						end
					end
				end
				r = random_request();
				r.out_rows = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(1, 8))
					: 16'($urandom_range(1, 4));
				r.out_cols = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(1, 8))
					: 16'($urandom_range(1, 4));
				send_request(1'b1, r, 1'b0, '0);
				ticks = int'(r.out_rows) * int'(r.out_cols) * nch;
				items_sent += ticks + 1;
				repeat (ticks)
					send_request(1'($urandom_range(0, 1)), random_request(), 1'b0, '0);
			end
		end

		drain_pipeline();
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
